// File: design/rsie_pkg.sv
// Shared constants, codes and types for the register subset instruction executor.
package rsie_pkg;

  localparam int LINE_BITS_DEF = 10;
  localparam int NUM_REGS      = 7;
  localparam int REG_W         = 8;
  localparam int REG_IDX_W     = 3;
  localparam int OP_W          = 4;
  localparam int LINE_W        = 10;
  localparam int CNT_W         = 16;
  localparam int STAT_W        = 2;

  // Opcodes of a pre-decoded request; codes above OP_HLT are unknown.
  localparam logic [OP_W-1:0] OP_NONE = 4'd0;
  localparam logic [OP_W-1:0] OP_MOV  = 4'd1;
  localparam logic [OP_W-1:0] OP_MVI  = 4'd2;
  localparam logic [OP_W-1:0] OP_DCR  = 4'd3;
  localparam logic [OP_W-1:0] OP_INR  = 4'd4;
  localparam logic [OP_W-1:0] OP_JNZ  = 4'd5;
  localparam logic [OP_W-1:0] OP_JZ   = 4'd6;
  localparam logic [OP_W-1:0] OP_HLT  = 4'd7;

  // Cycle cost added to the cycle counter per instruction class.
  localparam logic [CNT_W-1:0] CYC_SHORT = 16'd4;
  localparam logic [CNT_W-1:0] CYC_MVI   = 16'd7;

  typedef enum logic [STAT_W-1:0] {
    ST_RUN  = 2'd0,
    ST_HALT = 2'd1,
    ST_ERR  = 2'd2
  } run_stat_t;

  typedef logic [REG_W-1:0] reg_val_t;
  typedef reg_val_t [NUM_REGS-1:0] reg_file_t;

  // Architectural state apart from the line index, whose width is a parameter.
  typedef struct packed {
    reg_file_t        regs;
    logic             zero;
    logic [CNT_W-1:0] cyc;
    logic [CNT_W-1:0] instr;
    run_stat_t        status;
  } core_state_t;

  typedef struct packed {
    logic [OP_W-1:0]      req_type;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [REG_IDX_W-1:0] src_reg;
    logic [REG_W-1:0]     immediate;
    logic [LINE_W-1:0]    target_line;
  } instr_t;

endpackage

// File: design/rsie_in_if.sv
// Request channel: one pre-decoded instruction per handshake.
interface rsie_in_if;
  import rsie_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      req_type;
  logic [REG_IDX_W-1:0] dest_reg;
  logic [REG_IDX_W-1:0] src_reg;
  logic [REG_W-1:0]     immediate;
  logic [LINE_W-1:0]    target_line;

  modport source (
    output valid, req_type, dest_reg, src_reg, immediate, target_line,
    input  ready
  );

  modport sink (
    input  valid, req_type, dest_reg, src_reg, immediate, target_line,
    output ready
  );
endinterface

// File: design/rsie_out_if.sv
// Result channel: machine state after each executed request.
interface rsie_out_if;
  import rsie_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] next_line;
  logic [STAT_W-1:0] run_status;
  logic              zero;
  logic [REG_W-1:0]  reg_a;
  logic [REG_W-1:0]  reg_b;
  logic [REG_W-1:0]  reg_c;
  logic [REG_W-1:0]  reg_d;
  logic [REG_W-1:0]  reg_e;
  logic [REG_W-1:0]  reg_h;
  logic [REG_W-1:0]  reg_l;
  logic [CNT_W-1:0]  cycle_count;
  logic [CNT_W-1:0]  instr_count;

  modport source (
    output valid, next_line, run_status, zero, reg_a, reg_b, reg_c, reg_d,
           reg_e, reg_h, reg_l, cycle_count, instr_count,
    input  ready
  );

  modport sink (
    input  valid, next_line, run_status, zero, reg_a, reg_b, reg_c, reg_d,
           reg_e, reg_h, reg_l, cycle_count, instr_count,
    output ready
  );
endinterface

// File: design/rsie_exec.sv
// Next-state logic: executes one instruction against the current state.
module rsie_exec #(
  parameter int LINE_BITS = rsie_pkg::LINE_BITS_DEF
) (
  input  rsie_pkg::instr_t      instr,
  input  rsie_pkg::core_state_t cur,
  input  logic [LINE_BITS-1:0]  line_cur,
  output rsie_pkg::core_state_t nxt,
  output logic [LINE_BITS-1:0]  line_nxt
);
  import rsie_pkg::*;

  logic [LINE_BITS-1:0] seq_line;
  logic [LINE_BITS-1:0] tgt_line;
  logic                 dst_ok;
  logic                 src_ok;
  reg_val_t             dst_val;
  reg_val_t             src_val;
  reg_val_t             step_val;

  assign seq_line = line_cur + LINE_BITS'(1);
  assign tgt_line = LINE_BITS'(instr.target_line);
  assign dst_ok   = (instr.dest_reg < REG_IDX_W'(NUM_REGS));
  assign src_ok   = (instr.src_reg < REG_IDX_W'(NUM_REGS));
  assign dst_val  = dst_ok ? cur.regs[instr.dest_reg] : '0;
  assign src_val  = src_ok ? cur.regs[instr.src_reg] : '0;
  assign step_val = (instr.req_type == OP_INR) ? dst_val + 8'd1 : dst_val - 8'd1;

  always_comb begin
    nxt      = cur;
    line_nxt = line_cur;
    if (cur.status == ST_RUN) begin
      case (instr.req_type)
        OP_NONE: begin
          line_nxt = seq_line;
        end
        OP_MOV: begin
          if (dst_ok) begin
            nxt.regs[instr.dest_reg] = src_val;
          end
          nxt.cyc   = cur.cyc + CYC_SHORT;
          nxt.instr = cur.instr + 16'd1;
          line_nxt  = seq_line;
        end
        OP_MVI: begin
          if (dst_ok) begin
            nxt.regs[instr.dest_reg] = instr.immediate;
          end
          nxt.cyc   = cur.cyc + CYC_MVI;
          nxt.instr = cur.instr + 16'd1;
          line_nxt  = seq_line;
        end
        OP_DCR, OP_INR: begin
          if (dst_ok) begin
            nxt.regs[instr.dest_reg] = step_val;
            nxt.zero                 = (step_val == '0);
          end
          nxt.cyc   = cur.cyc + CYC_SHORT;
          nxt.instr = cur.instr + 16'd1;
          line_nxt  = seq_line;
        end
        OP_JNZ: begin
          line_nxt = cur.zero ? seq_line : tgt_line;
        end
        OP_JZ: begin
          line_nxt = cur.zero ? tgt_line : seq_line;
        end
        OP_HLT: begin
          nxt.status = ST_HALT;
        end
        default: begin
          nxt.status = ST_ERR;
        end
      endcase
    end
  end
endmodule

// File: design/register_subset_instruction_executor.sv
// Top level: register subset instruction executor with registered result.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle unless a result waits untaken; the state
//   update (register file read, increment or move, write) is combinational.
// in_req.ready is high whenever the result register is empty or being taken.
// Reset (rst_n, synchronous, active low): registers, flag, line index,
//   counters and status go to zero; the result register empties.
module register_subset_instruction_executor #(
  parameter int LINE_BITS = rsie_pkg::LINE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  rsie_in_if.sink    in_req,
  rsie_out_if.source out_res
);
  import rsie_pkg::*;

  // Architectural state.
  core_state_t          state_r;
  logic [LINE_BITS-1:0] line_r;
  core_state_t          state_nxt;
  logic [LINE_BITS-1:0] line_nxt;

  // Result register: holds the state after the last accepted request until
  // the sink takes it, so the next request can enter meanwhile.
  logic              res_valid_r;
  core_state_t       res_state_r;
  logic [LINE_W-1:0] res_line_r;

  instr_t instr;
  logic   req_take;

  assign instr.req_type    = in_req.req_type;
  assign instr.dest_reg    = in_req.dest_reg;
  assign instr.src_reg     = in_req.src_reg;
  assign instr.immediate   = in_req.immediate;
  assign instr.target_line = in_req.target_line;

  assign in_req.ready = !res_valid_r || out_res.ready;
  assign req_take     = in_req.valid && in_req.ready;

  rsie_exec #(
    .LINE_BITS (LINE_BITS)
  ) u_exec (
    .instr    (instr),
    .cur      (state_r),
    .line_cur (line_r),
    .nxt      (state_nxt),
    .line_nxt (line_nxt)
  );

  // State and valid flag: control, cleared on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      line_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (req_take) begin
        state_r     <= state_nxt;
        line_r      <= line_nxt;
        res_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: loaded with each accepted request, no reset needed.
  always_ff @(posedge clk) begin
    if (req_take) begin
      res_state_r <= state_nxt;
      res_line_r  <= LINE_W'(line_nxt);
    end
  end

  assign out_res.valid       = res_valid_r;
  assign out_res.next_line   = res_line_r;
  assign out_res.run_status  = res_state_r.status;
  assign out_res.zero        = res_state_r.zero;
  assign out_res.reg_a       = res_state_r.regs[0];
  assign out_res.reg_b       = res_state_r.regs[1];
  assign out_res.reg_c       = res_state_r.regs[2];
  assign out_res.reg_d       = res_state_r.regs[3];
  assign out_res.reg_e       = res_state_r.regs[4];
  assign out_res.reg_h       = res_state_r.regs[5];
  assign out_res.reg_l       = res_state_r.regs[6];
  assign out_res.cycle_count = res_state_r.cyc;
  assign out_res.instr_count = res_state_r.instr;
endmodule

// File: design/rsie_checker.sv
// Port-level checks for the executor, bound to its top level.
module rsie_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rsie_pkg::STAT_W-1:0] out_run_status,
  input logic [rsie_pkg::REG_W-1:0]  out_reg_a,
  input logic [rsie_pkg::CNT_W-1:0]  out_cycle_count,
  input logic [rsie_pkg::CNT_W-1:0]  out_instr_count
);
  import rsie_pkg::*;

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_run_status)
      && $stable(out_reg_a) && $stable(out_cycle_count))
    else $error("result changed while stalled");

  // Every accepted request yields a result the next cycle.
  a_req_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // Requests are only held off by a pending, untaken result.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request stalled without cause");

  // Once halted or in error, the following result repeats the frozen state.
  a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_run_status != STAT_W'(ST_RUN)) ##1 out_valid
      |-> $stable(out_run_status) && $stable(out_reg_a)
        && $stable(out_cycle_count) && $stable(out_instr_count))
    else $error("state changed after halt");
endmodule

bind register_subset_instruction_executor rsie_checker u_rsie_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_run_status  (out_res.run_status),
  .out_reg_a       (out_res.reg_a),
  .out_cycle_count (out_res.cycle_count),
  .out_instr_count (out_res.instr_count)
);
